>>> rtl/core/read_dust_complexity_filter_macros.svh
// Assertion macros for the block's top-level RTL file.
`ifndef READ_DUST_COMPLEXITY_FILTER_MACROS_SVH
`define READ_DUST_COMPLEXITY_FILTER_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define RDCF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication checked in the same cycle.
`define RDCF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/rdcf_pkg.sv
package rdcf_pkg;

  // Longest read that is still counted.
  localparam int MAX_LEN = 4095;

  localparam int LEN_W = $clog2(MAX_LEN + 1);
  localparam int BIN_W = LEN_W;
  localparam longint SCORE_MAX = (longint'(MAX_LEN) * longint'(MAX_LEN - 1)) / 2;
  localparam int SCORE_W = $clog2(SCORE_MAX + 1);
  localparam int LIM_W = 2 * LEN_W;
  localparam int CMP_W = (SCORE_W > LIM_W) ? SCORE_W : LIM_W;

  localparam int NUM_BINS = 64;
  localparam int BIN_IDX_W = $clog2(NUM_BINS);
  localparam int CODE_W = 2;
  localparam int PREV_W = BIN_IDX_W - CODE_W;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);

  localparam int OUT_LEN_W = 12;
  localparam int OUT_SCORE_W = 23;

  // Reads shorter than this are always low complexity.
  localparam int SHORT_READ = 6;
  localparam int LIM_OFFSET = 2;
  // First character position that completes a trinucleotide.
  localparam int FIRST_BIN_POS = 2;

  localparam logic [7:0] CHAR_A = 8'h41;
  localparam logic [7:0] CHAR_C = 8'h43;
  localparam logic [7:0] CHAR_G = 8'h47;
  localparam logic [7:0] CHAR_T = 8'h54;

  typedef struct packed {
    logic [7:0] symbol;
    logic       last;
  } sym_in_t;

  typedef struct packed {
    logic                   all_acgt;
    logic                   high_complexity;
    logic [OUT_SCORE_W-1:0] dust_score;
    logic [OUT_LEN_W-1:0]   read_length;
    logic                   overflow;
  } result_t;

  // One classified item handed from the front to the back.
  typedef struct packed {
    logic                 do_bin;
    logic [BIN_IDX_W-1:0] idx;
    logic                 last;
    logic                 all_acgt;
    logic                 too_long;
    logic [LEN_W-1:0]     len;
    logic [LIM_W-1:0]     lim;
  } work_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic pop;
    logic done_last;
  } bk_stat_t;

  function automatic logic [OUT_LEN_W-1:0] sat_len(input logic [LEN_W-1:0] l);
    logic [LEN_W+OUT_LEN_W-1:0] w;
    w = (LEN_W + OUT_LEN_W)'(l);
    if (w > (LEN_W + OUT_LEN_W)'({OUT_LEN_W{1'b1}})) begin
      return {OUT_LEN_W{1'b1}};
    end
    return w[OUT_LEN_W-1:0];
  endfunction

  function automatic logic [OUT_SCORE_W-1:0] sat_score(input logic [SCORE_W-1:0] s);
    logic [SCORE_W+OUT_SCORE_W-1:0] w;
    w = (SCORE_W + OUT_SCORE_W)'(s);
    if (w > (SCORE_W + OUT_SCORE_W)'({OUT_SCORE_W{1'b1}})) begin
      return {OUT_SCORE_W{1'b1}};
    end
    return w[OUT_SCORE_W-1:0];
  endfunction

endpackage

>>> rtl/core/rdcf_ram.sv
module rdcf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Read-first: a read at the written address returns the old word.
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

endmodule

>>> rtl/core/rdcf_front.sv
module rdcf_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  rdcf_pkg::sym_in_t in_item_i,
  output logic             in_stall_o,
  input  rdcf_pkg::q_stat_t q_stat_i,
  output logic             push_o,
  output rdcf_pkg::work_t  entry_o
);

  logic [rdcf_pkg::PREV_W-1:0] prev_q, prev_d;
  logic [rdcf_pkg::LEN_W-1:0]  count_q, count_d;
  logic                        acgt_q, acgt_d;
  logic                        long_q, long_d;

  logic [rdcf_pkg::CODE_W-1:0] code;
  logic                        at_max;
  logic                        is_acgt;
  logic [rdcf_pkg::LEN_W-1:0]  len_new;
  logic [rdcf_pkg::LEN_W-1:0]  qtr;
  logic [rdcf_pkg::LEN_W-1:0]  rem6;
  logic [rdcf_pkg::LIM_W-1:0]  prod;

  assign in_stall_o = q_stat_i.full;
  assign push_o     = in_valid_i && !q_stat_i.full;

  always_comb begin
    code    = in_item_i.symbol[2:1];
    at_max  = (count_q == rdcf_pkg::LEN_W'(rdcf_pkg::MAX_LEN));
    is_acgt = (in_item_i.symbol == rdcf_pkg::CHAR_A) || (in_item_i.symbol == rdcf_pkg::CHAR_C) ||
              (in_item_i.symbol == rdcf_pkg::CHAR_G) || (in_item_i.symbol == rdcf_pkg::CHAR_T);
    len_new = at_max ? count_q : count_q + rdcf_pkg::LEN_W'(1);
    qtr     = (len_new - rdcf_pkg::LEN_W'(rdcf_pkg::LIM_OFFSET)) >> 2;
    rem6    = len_new - rdcf_pkg::LEN_W'(rdcf_pkg::SHORT_READ);
    prod    = rdcf_pkg::LIM_W'(qtr) * rdcf_pkg::LIM_W'(rem6);

    entry_o.do_bin   = !at_max && (count_q >= rdcf_pkg::LEN_W'(rdcf_pkg::FIRST_BIN_POS));
    entry_o.idx      = {prev_q, code};
    entry_o.last     = in_item_i.last;
    entry_o.all_acgt = acgt_q && is_acgt;
    entry_o.too_long = long_q || at_max;
    entry_o.len      = len_new;
    entry_o.lim      = (len_new >= rdcf_pkg::LEN_W'(rdcf_pkg::SHORT_READ)) ? (prod >> 3) : '0;

    prev_d  = prev_q;
    count_d = count_q;
    acgt_d  = acgt_q;
    long_d  = long_q;
    if (push_o) begin
      if (in_item_i.last) begin
        prev_d  = '0;
        count_d = '0;
        acgt_d  = 1'b1;
        long_d  = 1'b0;
      end else begin
        prev_d  = at_max ? prev_q : {prev_q[rdcf_pkg::PREV_W-rdcf_pkg::CODE_W-1:0], code};
        count_d = len_new;
        acgt_d  = entry_o.all_acgt;
        long_d  = entry_o.too_long;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q  <= '0;
      count_q <= '0;
      acgt_q  <= 1'b1;
      long_q  <= 1'b0;
    end else begin
      prev_q  <= prev_d;
      count_q <= count_d;
      acgt_q  <= acgt_d;
      long_q  <= long_d;
    end
  end

endmodule

>>> rtl/core/rdcf_queue.sv
module rdcf_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  rdcf_pkg::work_t    entry_i,
  input  logic               pop_i,
  output rdcf_pkg::work_t    head_o,
  output rdcf_pkg::q_stat_t  stat_o
);

  rdcf_pkg::work_t              mem_q [rdcf_pkg::QUEUE_DEPTH];
  logic [rdcf_pkg::QPTR_W-1:0]  wr_q, wr_d;
  logic [rdcf_pkg::QPTR_W-1:0]  rd_q, rd_d;
  logic [rdcf_pkg::QPTR_W:0]    cnt_q, cnt_d;

  always_comb begin
    head_o       = mem_q[rd_q];
    stat_o.full  = (cnt_q == (rdcf_pkg::QPTR_W + 1)'(rdcf_pkg::QUEUE_DEPTH));
    stat_o.empty = (cnt_q == '0);
    wr_d  = push_i ? wr_q + rdcf_pkg::QPTR_W'(1) : wr_q;
    rd_d  = pop_i ? rd_q + rdcf_pkg::QPTR_W'(1) : rd_q;
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + (rdcf_pkg::QPTR_W + 1)'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - (rdcf_pkg::QPTR_W + 1)'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

>>> rtl/core/rdcf_back.sv
module rdcf_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rdcf_pkg::work_t    head_i,
  input  rdcf_pkg::q_stat_t  q_stat_i,
  output rdcf_pkg::bk_stat_t stat_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output rdcf_pkg::result_t  out_item_o
);

  logic                          s_valid_q, s_valid_d;
  rdcf_pkg::work_t               s_item_q;
  logic [rdcf_pkg::NUM_BINS-1:0] bin_vld_q, bin_vld_d;
  logic [rdcf_pkg::SCORE_W-1:0]  score_q, score_d;
  logic                          fwd_valid_q, fwd_valid_d;
  logic [rdcf_pkg::BIN_IDX_W-1:0] fwd_idx_q;
  logic [rdcf_pkg::BIN_W-1:0]    fwd_val_q;
  logic                          out_valid_q, out_valid_d;
  rdcf_pkg::result_t             out_item_q;

  logic                           out_free;
  logic                           s_done;
  logic                           s_free;
  logic                           pop;
  logic                           we;
  logic [rdcf_pkg::BIN_IDX_W-1:0] raddr;
  logic [rdcf_pkg::BIN_W-1:0]     ram_rdata;
  logic [rdcf_pkg::BIN_W-1:0]     m;
  logic [rdcf_pkg::BIN_W-1:0]     m_inc;
  logic [rdcf_pkg::SCORE_W-1:0]   score_new;
  rdcf_pkg::result_t              res;

  rdcf_ram #(
    .WIDTH (rdcf_pkg::BIN_W),
    .DEPTH (rdcf_pkg::NUM_BINS)
  ) u_bins (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (s_item_q.idx),
    .wdata_i (m_inc),
    .raddr_i (raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    out_free = !out_valid_q || !out_stall_i;
    s_done   = s_valid_q && (!s_item_q.last || out_free);
    s_free   = !s_valid_q || s_done;
    pop      = s_free && !q_stat_i.empty;
    // A held item keeps re-reading its own bin so the read data stays current.
    raddr    = s_free ? head_i.idx : s_item_q.idx;

    // The bin written on the previous edge is not yet in the read data.
    if (fwd_valid_q && (fwd_idx_q == s_item_q.idx)) begin
      m = fwd_val_q;
    end else if (bin_vld_q[s_item_q.idx]) begin
      m = ram_rdata;
    end else begin
      m = '0;
    end
    m_inc     = m + rdcf_pkg::BIN_W'(1);
    score_new = s_item_q.do_bin ? score_q + rdcf_pkg::SCORE_W'(m) : score_q;
    we        = s_done && s_item_q.do_bin;

    res.all_acgt        = s_item_q.all_acgt;
    res.high_complexity = rdcf_pkg::CMP_W'(score_new) < rdcf_pkg::CMP_W'(s_item_q.lim);
    res.dust_score      = rdcf_pkg::sat_score(score_new);
    res.read_length     = rdcf_pkg::sat_len(s_item_q.len);
    res.overflow        = s_item_q.too_long;

    s_valid_d = pop ? 1'b1 : (s_free ? 1'b0 : s_valid_q);

    bin_vld_d   = bin_vld_q;
    score_d     = score_q;
    fwd_valid_d = 1'b0;
    if (s_done) begin
      if (s_item_q.last) begin
        bin_vld_d = '0;
        score_d   = '0;
      end else begin
        score_d     = score_new;
        fwd_valid_d = s_item_q.do_bin;
        if (s_item_q.do_bin) begin
          bin_vld_d[s_item_q.idx] = 1'b1;
        end
      end
    end

    out_valid_d = (s_done && s_item_q.last) || (out_valid_q && out_stall_i);

    stat_o.pop       = pop;
    stat_o.done_last = s_done && s_item_q.last;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  always_ff @(posedge clk_i) begin
    if (pop) begin
      s_item_q <= head_i;
    end
    if (we) begin
      fwd_idx_q <= s_item_q.idx;
      fwd_val_q <= m_inc;
    end
    if (s_done && s_item_q.last) begin
      out_item_q <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid_q   <= 1'b0;
      bin_vld_q   <= '0;
      score_q     <= '0;
      fwd_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s_valid_q   <= s_valid_d;
      bin_vld_q   <= bin_vld_d;
      score_q     <= score_d;
      fwd_valid_q <= fwd_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

>>> rtl/core/read_dust_complexity_filter.sv
// Trinucleotide DUST low-complexity filter for a stream of reads.
// The input channel carries one character byte of a read per item, with a
// flag on the final byte. The output channel carries one result item per
// read: the DUST score, the read length, an all-ACGT flag, an overflow flag
// and a high-complexity flag. Both channels use valid and stall; an item
// moves at a rising edge where valid is high and stall is low.
// The block sustains one input item per cycle while the output is not
// stalled. A front stage tracks the read position and the last two codes
// and computes the length limit; a four-entry queue decouples it from the
// back stage, which does one read-modify-write of the 64-entry bin memory
// per cycle. With nothing stalled, a result passes from the queue through
// the back-stage item register into the output register.
// When the output is stalled, the finished result waits in the output
// register and the back stage holds the next last item; bytes keep flowing
// in until the queue fills, then in_stall_o rises.
// Reset clears all read state and empties the queue and pipeline; the bin
// memory is cleared at once through per-bin valid flags.
`include "read_dust_complexity_filter_macros.svh"

module read_dust_complexity_filter (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  rdcf_pkg::sym_in_t in_item_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output rdcf_pkg::result_t out_item_o
);

  logic               push;
  rdcf_pkg::work_t    entry;
  rdcf_pkg::work_t    head;
  rdcf_pkg::q_stat_t  q_stat;
  rdcf_pkg::bk_stat_t bk_stat;

  // Front: character classification, position tracking and the length limit.
  rdcf_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_item_i  (in_item_i),
    .in_stall_o (in_stall_o),
    .q_stat_i   (q_stat),
    .push_o     (push),
    .entry_o    (entry)
  );

  // Work queue between the two halves.
  rdcf_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (entry),
    .pop_i   (bk_stat.pop),
    .head_o  (head),
    .stat_o  (q_stat)
  );

  // Back: bin update, score accumulation and result formatting.
  rdcf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .q_stat_i    (q_stat),
    .stat_o      (bk_stat),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  `RDCF_ASSERT_IMP(a_no_push_full, push, !q_stat.full, "item pushed into a full queue")
  `RDCF_ASSERT_IMP(a_no_pop_empty, bk_stat.pop, !q_stat.empty, "item popped from an empty queue")
  `RDCF_ASSERT(a_queue_sane, !(q_stat.full && q_stat.empty), "queue both full and empty")
  `RDCF_ASSERT_IMP(a_out_from_last, $rose(out_valid_o), $past(bk_stat.done_last), "result without a last item")

endmodule
